[hw/rtl/tcg_pkg.sv]
// Shared types and constants of the text console glyph renderer.
// No dependencies; the renderer, its checkers and its testbench refer to this package.
package tcg_pkg;

    // Request actions.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_PRINT = 2'd1;
    localparam logic [1:0] ACT_HOME  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FG_COLOR      = 3'd0;
    localparam logic [2:0] CFG_BG_COLOR      = 3'd1;
    localparam logic [2:0] CFG_X_OFFSET      = 3'd2;
    localparam logic [2:0] CFG_Y_OFFSET      = 3'd3;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd5;

    // Character codes with special handling.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;

    // Width of a character cell in pixels.
    localparam int CELL_WIDTH = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DECODE,
        ST_SCROLL,
        ST_ROWS,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  pixel_mask;
        logic [31:0] fore_out;
        logic [31:0] back_out;
        logic        last;
    } result_t;

endpackage

[hw/rtl/tcg_ifs.sv]
// Request and result channel interfaces of the text console glyph renderer.
// No dependencies.
interface tcg_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] font_bits;

    modport source (output valid, action, char_code, glyph_row, font_bits, input ready);
    modport sink   (input valid, action, char_code, glyph_row, font_bits, output ready);
endinterface

interface tcg_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  pixel_mask;
    logic [31:0] fore_out;
    logic [31:0] back_out;
    logic        last;

    modport source (output valid, kind, pixel_x, pixel_y, pixel_mask, fore_out, back_out, last,
                    input ready);
    modport sink   (input valid, kind, pixel_x, pixel_y, pixel_mask, fore_out, back_out, last,
                    output ready);
endinterface

[hw/rtl/text_console_glyph_renderer.sv]
// A print request steps through prep and decode, a scroll command if the screen
// scrolls, then its glyph rows, one per cycle from the single font read port while the
// result side does not stall; a font load is written at once and leaves the block ready.
// Reset (rst_n, asynchronous, active low) homes the cursor to zero and loads the register
// defaults; the font memory is not cleared and holds no valid data until it is loaded.
// Depends on tcg_pkg, tcg_ifs and tcg_ram.
module text_console_glyph_renderer #(
    parameter int GLYPH_COUNT  = 256,
    parameter int GLYPH_HEIGHT = 16,
    parameter int COORD_BITS   = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    tcg_cmd_if.sink     cmd,
    tcg_res_if.source   res
);

    // The font memory is addressed as {glyph, row}; each glyph owns a power-of-two slot
    // of rows so that no multiplication sits in the address path.
    localparam int CODE_W     = $clog2(GLYPH_COUNT);
    localparam int ROW_W      = $clog2(GLYPH_HEIGHT);
    localparam int ADDR_W     = CODE_W + ROW_W;
    localparam int FONT_DEPTH = 1 << ADDR_W;
    localparam int CNT_W      = $clog2(GLYPH_HEIGHT + 1);

    // Cursor compares run one bit wider than any operand so that nothing wraps.
    localparam int CMP_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;

    // The usable height is the screen height rounded down to whole text rows. The
    // quotient comes from a multiplication by a scaled reciprocal, exact for 12-bit input.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
    localparam int PROD_W      = 28;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // Configuration registers.
    logic [31:0] fg_color_reg;
    logic [31:0] bg_color_reg;
    logic [11:0] x_offset_reg;
    logic [11:0] y_offset_reg;
    logic [11:0] screen_width_reg;
    logic [11:0] screen_height_reg;

    // Usable height pipeline: two register stages behind screen_height_reg. A print
    // request reads it only in its decode state, which follows the prep state, so a
    // register write just before the request is always seen.
    logic [PROD_W-1:0] height_prod;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;
    logic [11:0]       end_y_reg;
    logic [11:0]       end_y_next;

    // Control state.
    tcg_pkg::state_t state_reg, state_next;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [CNT_W-1:0]      rd_row_reg, rd_row_next;
    logic [ROW_W-1:0]      pend_row_reg, pend_row_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  scroll_last_reg, scroll_last_next;
    logic                  out_valid_reg, out_valid_next;

    // Request payload held while a print is worked on.
    logic [7:0] code_reg, code_next;
    logic       code_ok_reg, code_ok_next;

    // Result register.
    tcg_pkg::result_t out_reg;
    tcg_pkg::result_t out_item;
    logic             out_load;
    logic             out_free;

    // Font memory ports.
    logic              font_we;
    logic [ADDR_W-1:0] font_waddr;
    logic              font_re;
    logic [ADDR_W-1:0] font_raddr;
    logic [7:0]        font_rdata;

    // Cursor tests and derived values.
    logic [11:0]       end_x;
    logic              fits_y;
    logic              wrap_x;
    logic              load_ok;
    logic              row_load;
    logic              row_last;
    logic [COORD_BITS-1:0] home_x;
    logic [COORD_BITS-1:0] home_y;

    tcg_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .waddr (font_waddr),
        .wdata (cmd.font_bits),
        .re    (font_re),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg      <= 32'h00FF_FFFF;
            bg_color_reg      <= 32'h0000_0000;
            x_offset_reg      <= 12'd0;
            y_offset_reg      <= 12'd0;
            screen_width_reg  <= 12'd640;
            screen_height_reg <= 12'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcg_pkg::CFG_FG_COLOR:      fg_color_reg      <= cfg_data;
                tcg_pkg::CFG_BG_COLOR:      bg_color_reg      <= cfg_data;
                tcg_pkg::CFG_X_OFFSET:      x_offset_reg      <= cfg_data[11:0];
                tcg_pkg::CFG_Y_OFFSET:      y_offset_reg      <= cfg_data[11:0];
                tcg_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                tcg_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Usable height: quotient first, then back to pixels.
    assign height_prod = PROD_W'(screen_height_reg) * PROD_W'(RECIP);
    assign quot_next   = height_prod[PROD_W-1:RECIP_SHIFT];
    assign end_y_next  = 12'(16'(quot_reg) * 16'(GLYPH_HEIGHT));

    // The usable width only drops the low three bits.
    assign end_x = {screen_width_reg[11:3], 3'b000};

    // A newline moves down a text row only while the next row still lies inside the
    // usable height; otherwise the screen scrolls and the cursor row stays.
    assign fits_y = (CMP_W'(cursor_y_reg) + CMP_W'(GLYPH_HEIGHT)) < CMP_W'(end_y_reg);
    // A glyph that would cross the right edge starts a new line first.
    assign wrap_x = (CMP_W'(cursor_x_reg) + CMP_W'(tcg_pkg::CELL_WIDTH)) > CMP_W'(end_x);

    assign home_x = COORD_BITS'(x_offset_reg);
    assign home_y = COORD_BITS'(y_offset_reg);

    // Font loads outside the glyph set or past the glyph height are dropped.
    assign load_ok = ({1'b0, cmd.glyph_row} < 5'(GLYPH_HEIGHT))
                  && ({1'b0, cmd.char_code} < 9'(GLYPH_COUNT));
    assign font_waddr = {cmd.char_code[CODE_W-1:0], cmd.glyph_row[ROW_W-1:0]};
    assign font_raddr = {code_reg[CODE_W-1:0], rd_row_reg[ROW_W-1:0]};

    // The result register frees up when it is empty or being taken this cycle.
    assign out_free = !out_valid_reg || res.ready;

    // Glyph rows stream through the memory read register: a row read is pending once
    // issued, and it moves into the result register as soon as that is free. The next
    // read is issued only when the pending slot is empty or draining in this cycle, so
    // stalls on the result side never lose font data.
    assign row_load = (state_reg == tcg_pkg::ST_ROWS) && pend_valid_reg && out_free;
    assign row_last = (pend_row_reg == ROW_W'(GLYPH_HEIGHT - 1));
    assign font_re  = (state_reg == tcg_pkg::ST_ROWS)
                   && (rd_row_reg < CNT_W'(GLYPH_HEIGHT))
                   && (!pend_valid_reg || row_load);

    always_comb
    begin
        state_next       = state_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        rd_row_next      = rd_row_reg;
        pend_row_next    = pend_row_reg;
        pend_valid_next  = pend_valid_reg;
        scroll_last_next = scroll_last_reg;
        code_next        = code_reg;
        code_ok_next     = code_ok_reg;
        out_load         = 1'b0;
        out_item         = '0;
        font_we          = 1'b0;
        cmd.ready        = (state_reg == tcg_pkg::ST_IDLE);

        // Pending row bookkeeping.
        if (font_re)
        begin
            rd_row_next     = rd_row_reg + CNT_W'(1);
            pend_row_next   = rd_row_reg[ROW_W-1:0];
            pend_valid_next = 1'b1;
        end
        else if (row_load)
        begin
            pend_valid_next = 1'b0;
        end

        case (state_reg)
            tcg_pkg::ST_IDLE:
            begin
                // The block takes a new request here even while the last result of the
                // previous one still waits in the result register.
                if (cmd.valid)
                begin
                    code_next    = cmd.char_code;
                    code_ok_next = ({1'b0, cmd.char_code} < 9'(GLYPH_COUNT));
                    case (cmd.action)
                        tcg_pkg::ACT_LOAD:  font_we    = load_ok;
                        tcg_pkg::ACT_PRINT: state_next = tcg_pkg::ST_PREP;
                        tcg_pkg::ACT_HOME:  state_next = tcg_pkg::ST_CLEAR;
                        default: ;
                    endcase
                end
            end

            tcg_pkg::ST_PREP:
            begin
                // Gives the usable height pipeline time to settle after a register write.
                state_next = tcg_pkg::ST_DECODE;
            end

            tcg_pkg::ST_DECODE:
            begin
                rd_row_next = '0;
                case (code_reg)
                    tcg_pkg::CH_NUL,
                    tcg_pkg::CH_TAB:
                    begin
                        state_next = tcg_pkg::ST_IDLE;
                    end
                    tcg_pkg::CH_NL:
                    begin
                        cursor_x_next = home_x;
                        if (fits_y)
                        begin
                            cursor_y_next = cursor_y_reg + COORD_BITS'(GLYPH_HEIGHT);
                            state_next    = tcg_pkg::ST_IDLE;
                        end
                        else
                        begin
                            scroll_last_next = 1'b1;
                            state_next       = tcg_pkg::ST_SCROLL;
                        end
                    end
                    default:
                    begin
                        if (wrap_x)
                        begin
                            cursor_x_next = home_x;
                            if (fits_y)
                            begin
                                cursor_y_next = cursor_y_reg + COORD_BITS'(GLYPH_HEIGHT);
                                state_next    = tcg_pkg::ST_ROWS;
                            end
                            else
                            begin
                                scroll_last_next = 1'b0;
                                state_next       = tcg_pkg::ST_SCROLL;
                            end
                        end
                        else
                        begin
                            state_next = tcg_pkg::ST_ROWS;
                        end
                    end
                endcase
            end

            tcg_pkg::ST_SCROLL:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_item.kind     = tcg_pkg::KIND_SCROLL;
                    out_item.back_out = bg_color_reg;
                    out_item.last     = scroll_last_reg;
                    state_next = scroll_last_reg ? tcg_pkg::ST_IDLE : tcg_pkg::ST_ROWS;
                end
            end

            tcg_pkg::ST_ROWS:
            begin
                if (row_load)
                begin
                    out_load            = 1'b1;
                    out_item.kind       = tcg_pkg::KIND_ROW;
                    out_item.pixel_x    = 12'(cursor_x_reg);
                    out_item.pixel_y    = 12'(cursor_y_reg) + 12'(pend_row_reg);
                    out_item.pixel_mask = code_ok_reg ? font_rdata : 8'h00;
                    out_item.fore_out   = fg_color_reg;
                    out_item.back_out   = bg_color_reg;
                    out_item.last       = row_last;
                    if (row_last)
                    begin
                        cursor_x_next = cursor_x_reg + COORD_BITS'(tcg_pkg::CELL_WIDTH);
                        state_next    = tcg_pkg::ST_IDLE;
                    end
                end
            end

            tcg_pkg::ST_CLEAR:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_item.kind     = tcg_pkg::KIND_CLEAR;
                    out_item.back_out = bg_color_reg;
                    out_item.last     = 1'b1;
                    cursor_x_next     = home_x;
                    cursor_y_next     = home_y;
                    state_next        = tcg_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcg_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcg_pkg::ST_IDLE;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            rd_row_reg      <= '0;
            pend_row_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            scroll_last_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            quot_reg        <= '0;
            end_y_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            rd_row_reg      <= rd_row_next;
            pend_row_reg    <= pend_row_next;
            pend_valid_reg  <= pend_valid_next;
            scroll_last_reg <= scroll_last_next;
            out_valid_reg   <= out_valid_next;
            quot_reg        <= quot_next;
            end_y_reg       <= end_y_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        code_ok_reg <= code_ok_next;
        if (out_load)
        begin
            out_reg <= out_item;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = out_reg.kind;
    assign res.pixel_x    = out_reg.pixel_x;
    assign res.pixel_y    = out_reg.pixel_y;
    assign res.pixel_mask = out_reg.pixel_mask;
    assign res.fore_out   = out_reg.fore_out;
    assign res.back_out   = out_reg.back_out;
    assign res.last       = out_reg.last;

endmodule

[hw/rtl/tcg_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/tcg_checker.sv]
// Port-level checks of the text console glyph renderer, bound to its top level.
// Depends on tcg_pkg and text_console_glyph_renderer.
module tcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  cmd_action,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_kind,
    input logic [11:0] res_pixel_x,
    input logic [11:0] res_pixel_y,
    input logic [7:0]  res_pixel_mask,
    input logic [31:0] res_fore_out,
    input logic [31:0] res_back_out,
    input logic        res_last
);

    // A stalled result keeps its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_pixel_x)
            && $stable(res_pixel_y) && $stable(res_pixel_mask) && $stable(res_fore_out)
            && $stable(res_back_out) && $stable(res_last))
        else $error("result payload changed while stalled");

    // A clear screen command is always the only result of its request.
    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == tcg_pkg::KIND_CLEAR) |-> res_last)
        else $error("clear command not marked last");

    // Scroll and clear commands carry only the background color.
    a_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res_kind == tcg_pkg::KIND_SCROLL) || (res_kind == tcg_pkg::KIND_CLEAR))
            |-> (res_pixel_x == 12'd0) && (res_pixel_y == 12'd0)
                && (res_pixel_mask == 8'd0) && (res_fore_out == 32'd0))
        else $error("scroll or clear command with stray fields");

    // A font load completes in its own cycle; a print occupies the block afterwards.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action == tcg_pkg::ACT_LOAD) |=> cmd_ready)
        else $error("font load stalled the request channel");

    a_print_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action == tcg_pkg::ACT_PRINT) |=> !cmd_ready)
        else $error("request taken while a print was in progress");

endmodule

bind text_console_glyph_renderer tcg_checker u_tcg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_action     (cmd.action),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_kind       (res.kind),
    .res_pixel_x    (res.pixel_x),
    .res_pixel_y    (res.pixel_y),
    .res_pixel_mask (res.pixel_mask),
    .res_fore_out   (res.fore_out),
    .res_back_out   (res.back_out),
    .res_last       (res.last)
);

[test/tcg_draw_checker.sv]
// Scoreboard for the text console glyph renderer: watches the request, result and
// configuration ports, predicts the draw commands and compares them as they leave.
// Depends on tcg_pkg and the tcg_cmd_if / tcg_res_if interfaces.
module tcg_draw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    tcg_cmd_if          cmd,
    tcg_res_if          res,
    output int          pending_draws,
    output int          mismatch_count
);
    import tcg_pkg::*;

    localparam int GLYPH_H = 16;

    logic [7:0]  glyph_rom [0:4095];
    logic [11:0] cur_x;
    logic [11:0] cur_y;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [11:0] margin_x;
    logic [11:0] top_y;
    logic [11:0] scr_w;
    logic [11:0] scr_h;

    result_t draw_queue [$];
    result_t burst [0:GLYPH_H];
    int      burst_len;

    task automatic add_result(input result_t item);
        burst[burst_len] = item;
        burst_len++;
    endtask

    // Scroll and clear commands carry only the background colour.
    function automatic result_t fill_command(input logic [1:0] k);
        result_t item;
        item = '0;
        item.kind = k;
        item.back_out = bg;
        return item;
    endfunction

    // Return to the margin and step down a text row, or scroll at the bottom edge.
    task automatic line_feed();
        int end_y;
        end_y = int'(scr_h) - (int'(scr_h) % GLYPH_H);
        cur_x = margin_x;
        if (int'(cur_y) + GLYPH_H < end_y)
            cur_y = cur_y + 12'(GLYPH_H);
        else
            add_result(fill_command(KIND_SCROLL));
    endtask

    task automatic predict_request(input logic [1:0] act, input logic [7:0] code,
                                   input logic [3:0] row, input logic [7:0] bits);
        int      end_x;
        result_t item;
        burst_len = 0;
        case (act)
            ACT_LOAD: glyph_rom[{code, row}] = bits;
            ACT_HOME:
            begin
                cur_x = margin_x;
                cur_y = top_y;
                add_result(fill_command(KIND_CLEAR));
            end
            ACT_PRINT:
            begin
                if (code == CH_NL)
                begin
                    line_feed();
                end
                else if (code != CH_NUL && code != CH_TAB)
                begin
                    end_x = int'(scr_w) - (int'(scr_w) % CELL_WIDTH);
                    if (int'(cur_x) + CELL_WIDTH > end_x)
                        line_feed();
                    for (int r = 0; r < GLYPH_H; r++)
                    begin
                        item = '0;
                        item.kind = KIND_ROW;
                        item.pixel_x = cur_x;
                        item.pixel_y = cur_y + 12'(r);
                        item.pixel_mask = glyph_rom[{code, 4'(r)}];
                        item.fore_out = fg;
                        item.back_out = bg;
                        add_result(item);
                    end
                    cur_x = cur_x + 12'(CELL_WIDTH);
                end
            end
            default: ;
        endcase
        for (int i = 0; i < burst_len; i++)
        begin
            item = burst[i];
            item.last = (i == burst_len - 1);
            draw_queue.push_back(item);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            cur_x = '0;
            cur_y = '0;
            fg = 32'h00FF_FFFF;
            bg = '0;
            margin_x = '0;
            top_y = '0;
            scr_w = 12'd640;
            scr_h = 12'd480;
            draw_queue.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (draw_queue.size() == 0)
                begin
                    $error("draw command 0x%0h arrived with nothing expected", res.kind);
                    mismatch_count++;
                end
                else
                begin
                    want = draw_queue.pop_front();
                    check_field("kind", want.kind, res.kind);
                    check_field("pixel_x", want.pixel_x, res.pixel_x);
                    check_field("pixel_y", want.pixel_y, res.pixel_y);
                    check_field("pixel_mask", want.pixel_mask, res.pixel_mask);
                    check_field("fore_out", want.fore_out, res.fore_out);
                    check_field("back_out", want.back_out, res.back_out);
                    check_field("last", want.last, res.last);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FG_COLOR:      fg = cfg_data;
                    CFG_BG_COLOR:      bg = cfg_data;
                    CFG_X_OFFSET:      margin_x = cfg_data[11:0];
                    CFG_Y_OFFSET:      top_y = cfg_data[11:0];
                    CFG_SCREEN_WIDTH:  scr_w = cfg_data[11:0];
                    CFG_SCREEN_HEIGHT: scr_h = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                predict_request(cmd.action, cmd.char_code, cmd.glyph_row, cmd.font_bits);
        end
        pending_draws = draw_queue.size();
    end

endmodule

[test/tb_text_console_glyph_renderer.sv]
// Top of the text console glyph renderer testbench: clock, reset, request traffic,
// configuration phases and the verdict; checking lives in tcg_draw_checker.
// Depends on tcg_pkg, tcg_ifs, the renderer RTL and tcg_draw_checker.
module tb_text_console_glyph_renderer;
    import tcg_pkg::*;

    // Action code that the block decodes to nothing.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // The quiet stretch lets a request with no output finish before a register write.
    localparam int SETTLE_CYCLES = 24;

    // Worst case is roughly 110 requests, each giving 17 commands, each held up by the
    // longest receiver stall, plus sender gaps and phase pauses. The limit takes that
    // several times over.
    localparam int CYCLE_LIMIT = 600000;

    // Random requests per configuration phase, five phases in all.
    localparam int RANDOM_PER_PHASE = 15;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          pending_draws;
    int          mismatch_count;
    int          cycle_count;

    tcg_cmd_if cmd ();
    tcg_res_if res ();

    text_console_glyph_renderer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .res       (res)
    );

    tcg_draw_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .res            (res),
        .pending_draws  (pending_draws),
        .mismatch_count (mismatch_count)
    );

    // The font store reads back garbage until written, so the stimulus keeps track
    // of which rows of each glyph it has loaded. Only glyphs whose sixteen rows are
    // all loaded are ever printed.
    logic [15:0] rows_loaded [0:255];
    logic [7:0]  printable [$];

    // While steady is set the sender issues requests back to back.
    bit steady;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // The run is bounded no matter what the block does.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL text_console_glyph_renderer");
            $finish;
        end
    end

    // Receiver: ready alternates between open and stalled stretches. One stall in eight
    // is drawn from a longer range than the rest. Some open stretches are long
    // enough for whole glyphs to stream through without a stall.
    initial
    begin
        int  hold;
        bit  open;
        hold = 0;
        open = 1'b0;
        res.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                open = !open;
                if (open)
                    hold = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150)
                                                       : $urandom_range(1, 12);
                else
                    hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
                res.ready <= open;
            end
            hold--;
        end
    end

    // Gap before a request: usually none, sometimes a short one, rarely a long one.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Font row data with the all-clear and all-set patterns well represented.
    function automatic logic [7:0] glyph_bits();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request was
    // taken. Valid stays high when the next request follows with no gap, so the
    // next call only replaces the payload.
    task automatic send_request(input logic [1:0] act, input logic [7:0] code,
                                input logic [3:0] row, input logic [7:0] bits);
        int gap;
        bit taken;
        gap = idle_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.action    <= act;
        cmd.char_code <= code;
        cmd.glyph_row <= row;
        cmd.font_bits <= bits;
        do
        begin
            @(posedge clk);
            taken = cmd.ready;
            @(negedge clk);
        end
        while (!taken);
    endtask

    task automatic note_row(input logic [7:0] code, input logic [3:0] row);
        if (rows_loaded[code] != 16'hFFFF)
        begin
            rows_loaded[code][row] = 1'b1;
            if (rows_loaded[code] == 16'hFFFF)
                printable.push_back(code);
        end
    endtask

    // Loads the first row_count rows of a glyph. A partial load is a broken
    // sequence: the glyph stays unprintable until its missing rows arrive.
    task automatic load_glyph(input logic [7:0] code, input int row_count);
        for (int r = 0; r < row_count; r++)
        begin
            send_request(ACT_LOAD, code, 4'(r), glyph_bits());
            note_row(code, 4'(r));
        end
    endtask

    task automatic print_char(input logic [7:0] code);
        send_request(ACT_PRINT, code, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    task automatic home_cursor();
        send_request(ACT_HOME, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
    endtask

    // Registers are only written with the block idle: every expected command has
    // come back and any request with no output has had time to finish.
    task automatic settle();
        cmd.valid <= 1'b0;
        while (pending_draws != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [31:0] fg, input logic [31:0] bg,
                                  input logic [11:0] xo, input logic [11:0] yo,
                                  input logic [11:0] w, input logic [11:0] h);
        settle();
        put_reg(CFG_FG_COLOR, fg);
        put_reg(CFG_BG_COLOR, bg);
        put_reg(CFG_X_OFFSET, {20'd0, xo});
        put_reg(CFG_Y_OFFSET, {20'd0, yo});
        put_reg(CFG_SCREEN_WIDTH, {20'd0, w});
        put_reg(CFG_SCREEN_HEIGHT, {20'd0, h});
        cfg_we <= 1'b0;
    endtask

    // Mostly prints of loaded glyphs and newlines, so the cursor walks across the
    // screen, wraps and scrolls. Glyph loads, partial loads, stray row loads, homes
    // and requests the block ignores are mixed in. Ignored requests do not count
    // toward the quota.
    task automatic random_traffic(input int quota);
        int          done;
        int          pick;
        int          row_count;
        logic [7:0]  code;
        done = 0;
        steady = ($urandom_range(0, 3) == 0);
        while (done < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5 || printable.size() == 0)
            begin
                code = 8'($urandom_range(0, 255));
                row_count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 16;
                load_glyph(code, row_count);
                done += row_count;
            end
            else if (pick < 58)
            begin
                print_char(printable[$urandom_range(0, printable.size() - 1)]);
                done++;
            end
            else if (pick < 70)
            begin
                print_char(CH_NL);
                done++;
            end
            else if (pick < 76)
            begin
                home_cursor();
                done++;
            end
            else if (pick < 82)
            begin
                print_char(($urandom_range(0, 1) == 0) ? CH_NUL : CH_TAB);
            end
            else if (pick < 86)
            begin
                send_request(ACT_UNUSED, 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                code = 8'($urandom_range(0, 255));
                row_count = $urandom_range(0, 15);
                send_request(ACT_LOAD, code, 4'(row_count), glyph_bits());
                note_row(code, 4'(row_count));
                done++;
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        logic [7:0] bits;
        for (int i = 0; i < 256; i++)
            rows_loaded[i] = '0;
        cycle_count = 0;
        steady = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_FG_COLOR;
        cfg_data      <= '0;
        cmd.valid     <= 1'b0;
        cmd.action    <= ACT_LOAD;
        cmd.char_code <= '0;
        cmd.glyph_row <= '0;
        cmd.font_bits <= '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings. Load the top glyph with the edge patterns in its first
        // rows, then exercise every action: a print, NUL and tab which draw nothing,
        // a newline, the unused action, home and clear, and a print after home.
        for (int r = 0; r < 16; r++)
        begin
            case (r)
                0:       bits = 8'h00;
                1:       bits = 8'hFF;
                2:       bits = 8'h80;
                3:       bits = 8'h01;
                default: bits = 8'($urandom_range(0, 255));
            endcase
            send_request(ACT_LOAD, 8'hFF, 4'(r), bits);
            note_row(8'hFF, 4'(r));
        end
        print_char(8'hFF);
        print_char(CH_NUL);
        print_char(CH_TAB);
        print_char(CH_NL);
        send_request(ACT_UNUSED, 8'hFF, 4'hF, 8'hFF);
        home_cursor();
        print_char(8'hFF);
        random_traffic(RANDOM_PER_PHASE);

        // Smallest screen: one cell wide and one row high. Every glyph after the first in a
        // line wraps and every wrap or newline scrolls, with the cursor row held in place.
        write_settings(32'h0000_0000, 32'hFFFF_FFFF, 12'd0, 12'd0, 12'd8, 12'd16);
        print_char(8'hFF);
        print_char(8'hFF);
        print_char(CH_NL);
        home_cursor();
        random_traffic(RANDOM_PER_PHASE);

        // Largest values: margin and top row at the far end, so wrapping draws at
        // the last column, the cursor overflows past the edge and row addresses
        // of a glyph roll over.
        write_settings(32'hFFFF_FFFF, 32'h0000_0000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        home_cursor();
        print_char(8'hFF);
        print_char(8'hFF);
        print_char(CH_NL);
        random_traffic(RANDOM_PER_PHASE);

        // A small screen with sizes off the cell grid, so wraps and scrolls are
        // frequent and the rounding down of width and height matters.
        write_settings($urandom, $urandom, 12'($urandom_range(0, 40)),
                       12'($urandom_range(0, 40)), 12'($urandom_range(8, 96)),
                       12'($urandom_range(16, 96)));
        home_cursor();
        random_traffic(RANDOM_PER_PHASE);

        // Anything the registers allow.
        write_settings($urandom, $urandom, 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(8, 4095)),
                       12'($urandom_range(16, 4095)));
        random_traffic(RANDOM_PER_PHASE);

        // Drain, then watch a while longer for any command nobody asked for.
        cmd.valid <= 1'b0;
        while (pending_draws != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES * 2) @(negedge clk);

        if (mismatch_count == 0 && pending_draws == 0)
            $display("PASS text_console_glyph_renderer");
        else
            $display("FAIL text_console_glyph_renderer");
        $finish;
    end

endmodule
